// ===== rtl/clqc_pkg.sv =====
// ----------------------------------------------------------------------------
// clqc_pkg: shared types and constants of the command link queue
// Item kinds, receive status codes, sequencer states and frame geometry.
// ----------------------------------------------------------------------------
package clqc_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned DELAY_W  = 20;
  localparam int unsigned ENTRY_W  = 56;
  localparam int unsigned FRAME_W  = 64;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned IN_DW    = 128;
  localparam int unsigned OUT_DW   = 152;

  localparam logic [LEN_W-1:0]   FRAME_BYTES = 7'd8;
  localparam logic [2:0]         LAST_BODY   = 3'd6;
  localparam logic [DELAY_W-1:0] DELAY_NUM   = 20'd1000000;
  localparam logic [4:0]         DIV_STEPS   = 5'd20;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_TX   = 2'd1,
    OP_RX   = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RX_NONE      = 3'd0,
    RX_OK        = 3'd1,
    RX_BAD_LEN   = 3'd2,
    RX_BAD_SUM   = 3'd3,
    RX_ZERO_RATE = 3'd4
  } rx_status_t;

  typedef enum logic [1:0] {
    CFG_SET_OPCODE = 2'd0,
    CFG_VOLT_TYPE  = 2'd1,
    CFG_CURR_TYPE  = 2'd2,
    CFG_RATE_TYPE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SUM,
    ST_CHECK,
    ST_DIV,
    ST_OUT
  } state_t;

  // handshake between sequencer and divider
  typedef struct packed {
    logic                start;
    logic [VALUE_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DELAY_W-1:0]  quotient;
  } div_rsp_t;

endpackage

// ===== rtl/command_link_queue_and_checksum_frames.sv =====
// ----------------------------------------------------------------------------
// command_link_queue_and_checksum_frames: device command queue and host frames
// Ring queue of device commands, 8-byte sum framing and host setting updates.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per item; in_tuser selects the kind (enqueue a device
//           command, transmitter idle slot, host frame received).
//   out_* : one result beat per input beat; out_tuser flags a frame to send,
//           out_tdata carries the frame, receive status, drop flag and the
//           current voltage, current and sample delay settings.
//   cfg_* : register writes (set opcode, voltage/current/rate type codes),
//           always ready, to be issued only while the block is idle.
// Sequence: one item at a time; an enqueue, an empty transmit slot, a
//   bad-length frame or an unused kind goes straight to the output register;
//   a transmit slot reads its entry, one 8-bit adder sums the seven body bytes
//   one a cycle and the sum fills the checksum byte; a host frame of the right
//   length is summed the same way and checked, and a rate setting then runs
//   the 20-step divider. in_tready returns right after the result is loaded,
//   so the next item is taken only once the last result is in that register.
// Reset: queue empty, settings zero, config codes back to 0/0/1/2.
//   Queue storage is not cleared; only entries written are ever read.
// Stall: a result waits in the output register; the next item may still be
//   taken, but its result holds the sequencer (in_tready low) until
//   out_tready frees the register.
// ----------------------------------------------------------------------------
module command_link_queue_and_checksum_frames #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input beats
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [7:0] dev_status, [15:8] dev_opcode, [23:16] dev_type, [55:24] dev_value,
  // [119:56] rx_frame, [126:120] rx_length, [127] zero pad
  input  logic [clqc_pkg::IN_DW-1:0]    in_tdata,
  // [1:0] op
  input  logic [1:0]                    in_tuser,
  // result beats
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [63:0] tx_frame, [66:64] rx_status, [67] queue_dropped,
  // [99:68] target_voltage, [131:100] target_current, [151:132] sample_delay
  output logic [clqc_pkg::OUT_DW-1:0]   out_tdata,
  // [0] tx_valid
  output logic                          out_tuser,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [7:0]                    cfg_data
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
  endfunction

  // input fields
  logic [7:0]                     in_status, in_opcode, in_type;
  logic [clqc_pkg::VALUE_W-1:0]   in_value;
  logic [clqc_pkg::FRAME_W-1:0]   in_frame;
  logic [clqc_pkg::LEN_W-1:0]     in_length;
  clqc_pkg::op_t                  in_op;

  assign in_status = in_tdata[7:0];
  assign in_opcode = in_tdata[15:8];
  assign in_type   = in_tdata[23:16];
  assign in_value  = in_tdata[55:24];
  assign in_frame  = in_tdata[119:56];
  assign in_length = in_tdata[126:120];
  assign in_op     = clqc_pkg::op_t'(in_tuser);

  // configuration codes
  logic [7:0] set_opcode_r, volt_type_r, curr_type_r, rate_type_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_opcode_r <= 8'd0;
      volt_type_r  <= 8'd0;
      curr_type_r  <= 8'd1;
      rate_type_r  <= 8'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (clqc_pkg::cfg_idx_t'(cfg_index))
        clqc_pkg::CFG_SET_OPCODE: set_opcode_r <= cfg_data;
        clqc_pkg::CFG_VOLT_TYPE:  volt_type_r  <= cfg_data;
        clqc_pkg::CFG_CURR_TYPE:  curr_type_r  <= cfg_data;
        clqc_pkg::CFG_RATE_TYPE:  rate_type_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  clqc_pkg::state_t state_r, state_nxt;
  clqc_pkg::op_t    op_r;

  logic [PTR_W-1:0]               wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]               count_r;
  logic [clqc_pkg::FRAME_W-1:0]   frame_r;
  logic [clqc_pkg::ENTRY_W-1:0]   rd_data_r;
  logic [7:0]                     sum_r;
  logic [2:0]                     idx_r;
  clqc_pkg::rx_status_t           status_r;
  logic                           drop_r;
  logic                           txv_r;
  logic [clqc_pkg::VALUE_W-1:0]   volt_r, curr_r;
  logic [clqc_pkg::DELAY_W-1:0]   delay_r;
  logic                           out_valid_r;
  logic                           out_user_r;
  logic [clqc_pkg::OUT_DW-1:0]    out_data_r;

  logic accept, mem_we, mem_re, out_load, div_start;
  logic sum_ok, is_set;
  logic [7:0] frm_opcode, frm_type;
  logic [clqc_pkg::VALUE_W-1:0] frm_value;

  clqc_pkg::div_req_t div_req;
  clqc_pkg::div_rsp_t div_rsp;

  assign frm_opcode = frame_r[15:8];
  assign frm_type   = frame_r[23:16];
  assign frm_value  = frame_r[55:24];
  assign sum_ok     = (sum_r == frame_r[63:56]);
  assign is_set     = (frm_opcode == set_opcode_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clqc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    out_load  = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      clqc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = clqc_pkg::ST_OUT;
          unique case (in_op)
            clqc_pkg::OP_ENQ: mem_we = (count_r != FULL_CNT);
            clqc_pkg::OP_TX: begin
              if (count_r != '0) begin
                mem_re    = 1'b1;
                state_nxt = clqc_pkg::ST_FETCH;
              end
            end
            clqc_pkg::OP_RX: begin
              if (in_length == clqc_pkg::FRAME_BYTES) begin
                state_nxt = clqc_pkg::ST_SUM;
              end
            end
            default: ;
          endcase
        end
      end
      clqc_pkg::ST_FETCH: state_nxt = clqc_pkg::ST_SUM;
      clqc_pkg::ST_SUM: begin
        if (idx_r == clqc_pkg::LAST_BODY) begin
          state_nxt = clqc_pkg::ST_CHECK;
        end
      end
      clqc_pkg::ST_CHECK: begin
        state_nxt = clqc_pkg::ST_OUT;
        if (op_r == clqc_pkg::OP_RX && sum_ok && is_set && frm_type != volt_type_r &&
            frm_type != curr_type_r && frm_type == rate_type_r && frm_value != '0) begin
          div_start = 1'b1;
          state_nxt = clqc_pkg::ST_DIV;
        end
      end
      clqc_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = clqc_pkg::ST_OUT;
        end
      end
      clqc_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = clqc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = clqc_pkg::ST_IDLE;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  // command store: one write port, one registered read port
  logic [clqc_pkg::ENTRY_W-1:0] mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr_r] <= {in_value, in_type, in_opcode, in_status};
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (mem_we) begin
        wr_ptr_r <= next_slot(wr_ptr_r);
        count_r  <= count_r + CNT_W'(1);
      end else if (mem_re) begin
        rd_ptr_r <= next_slot(rd_ptr_r);
        count_r  <= count_r - CNT_W'(1);
      end
    end
  end

  // item datapath: latch the item or fetch an entry, sum the body one byte a cycle, check or fill the sum
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_op;
      frame_r  <= in_frame;
      sum_r    <= '0;
      idx_r    <= '0;
      drop_r   <= (in_op == clqc_pkg::OP_ENQ) && (count_r == FULL_CNT);
      txv_r    <= mem_re;
      status_r <= (in_op != clqc_pkg::OP_RX) ? clqc_pkg::RX_NONE :
                  (in_length == clqc_pkg::FRAME_BYTES) ? clqc_pkg::RX_OK :
                  clqc_pkg::RX_BAD_LEN;
    end
    if (state_r == clqc_pkg::ST_FETCH) begin
      frame_r <= {8'h00, rd_data_r};
    end
    if (state_r == clqc_pkg::ST_SUM) begin
      sum_r <= sum_r + frame_r[8*idx_r +: 8];
      idx_r <= idx_r + 3'd1;
    end
    if (state_r == clqc_pkg::ST_CHECK) begin
      if (op_r == clqc_pkg::OP_TX) begin
        frame_r[63:56] <= sum_r;
      end else if (op_r == clqc_pkg::OP_RX) begin
        if (!sum_ok) begin
          status_r <= clqc_pkg::RX_BAD_SUM;
        end else if (is_set && frm_type != volt_type_r && frm_type != curr_type_r &&
                     frm_type == rate_type_r && frm_value == '0) begin
          status_r <= clqc_pkg::RX_ZERO_RATE;
        end
      end
    end
  end

  // settings: voltage tested first, then current, then rate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volt_r  <= '0;
      curr_r  <= '0;
      delay_r <= '0;
    end else begin
      if (state_r == clqc_pkg::ST_CHECK && op_r == clqc_pkg::OP_RX && sum_ok && is_set) begin
        if (frm_type == volt_type_r) begin
          volt_r <= frm_value;
        end else if (frm_type == curr_type_r) begin
          curr_r <= frm_value;
        end
      end
      if (state_r == clqc_pkg::ST_DIV && div_rsp.done) begin
        delay_r <= div_rsp.quotient;
      end
    end
  end

  assign div_req.start   = div_start;
  assign div_req.divisor = frm_value;

  clqc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // output register: hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_user_r <= txv_r;
      out_data_r <= {delay_r, curr_r, volt_r, drop_r, status_r,
                     (txv_r ? frame_r : {clqc_pkg::FRAME_W{1'b0}})};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/clqc_div.sv =====
// ----------------------------------------------------------------------------
// clqc_div: restoring divider for the sample delay
// Divides the fixed numerator by a 32-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module clqc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  clqc_pkg::div_req_t req,
  output clqc_pkg::div_rsp_t rsp
);

  logic                          busy_r;
  logic                          done_r;
  logic [4:0]                    cnt_r;
  logic [clqc_pkg::VALUE_W-1:0]  rem_r;
  logic [clqc_pkg::DELAY_W-1:0]  quo_r;
  logic [clqc_pkg::VALUE_W-1:0]  dvsr_r;
  logic [clqc_pkg::VALUE_W:0]    trial;
  logic [clqc_pkg::VALUE_W:0]    diff;
  logic                          fits;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_r, quo_r[clqc_pkg::DELAY_W-1]};
  assign diff  = trial - {1'b0, dvsr_r};
  assign fits  = !diff[clqc_pkg::VALUE_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == clqc_pkg::DIV_STEPS - 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= '0;
      quo_r  <= clqc_pkg::DELAY_NUM;
      dvsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[clqc_pkg::VALUE_W-1:0] : trial[clqc_pkg::VALUE_W-1:0];
      quo_r <= {quo_r[clqc_pkg::DELAY_W-2:0], fits};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== dv/command_link_queue_and_checksum_frames_tb.sv =====
// ----------------------------------------------------------------------------
// command_link_queue_and_checksum_frames_tb: self-checking bench
// Drives enqueue, transmit-slot and host-frame beats into the command link
// and holds its own model of the command queue, the frame checksum and the
// setting registers. Every result beat is compared field by field against the
// model's prediction. Three phases use different type codes and idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module command_link_queue_and_checksum_frames_tb;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned DRAIN_CYCLES = 40;

  // one input beat, unpacked
  typedef struct {
    clqc_pkg::op_t op;
    logic [7:0]    dev_status;
    logic [7:0]    dev_opcode;
    logic [7:0]    dev_kind;
    logic [31:0]   dev_value;
    logic [63:0]   rx_frame;
    logic [6:0]    rx_length;
  } link_item_t;

  // one result beat, unpacked
  typedef struct {
    logic                 tx_valid;
    logic [63:0]          tx_frame;
    clqc_pkg::rx_status_t rx_status;
    logic                 dropped;
    logic [31:0]          voltage;
    logic [31:0]          current;
    logic [19:0]          delay;
  } link_result_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [clqc_pkg::IN_DW-1:0]    in_tdata;
  logic [1:0]                    in_tuser;
  logic                          out_tvalid;
  logic                          out_tready;
  logic [clqc_pkg::OUT_DW-1:0]   out_tdata;
  logic                          out_tuser;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [1:0]                    cfg_index;
  logic [7:0]                    cfg_data;

  command_link_queue_and_checksum_frames #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Model state: queue, pointers, settings and the four type/opcode codes
  // --------------------------------------------------------------------------
  logic [55:0] cmd_store [QUEUE_DEPTH];
  int unsigned wr_ptr, rd_ptr, held_entries;
  logic [31:0] voltage_setting, current_setting;
  logic [19:0] delay_setting;
  logic [7:0]  set_code, voltage_code, current_code, rate_code;

  // bench bookkeeping
  link_item_t   pending_beats[$];   // beats still to be driven
  link_result_t expected_beats[$];  // predictions awaiting their result beat
  link_item_t   cur_beat;
  bit           in_taken;
  int unsigned  send_idle_pct, recv_idle_pct;
  int unsigned  error_count;
  int unsigned  beats_in, beats_out, frames_sent, enq_dropped;
  int unsigned  host_ok, host_rejected;

  // 8-bit sum of the seven body bytes
  function automatic logic [7:0] body_sum(input logic [55:0] body);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 7; i++) acc += body[8*i +: 8];
    return acc;
  endfunction

  function automatic logic [63:0] host_frame(input logic [7:0] status, input logic [7:0] opcode,
                                             input logic [7:0] kind, input logic [31:0] value);
    logic [55:0] body;
    body = {value, kind, opcode, status};
    return {body_sum(body), body};
  endfunction

  // Check length and sum, then apply a set-setting frame.
  function automatic clqc_pkg::rx_status_t apply_host_frame(input logic [63:0] frame,
                                                            input logic [6:0] len);
    logic [7:0]  opcode, kind;
    logic [31:0] value;
    if (len != clqc_pkg::FRAME_BYTES) return clqc_pkg::RX_BAD_LEN;
    if (body_sum(frame[55:0]) != frame[63:56]) return clqc_pkg::RX_BAD_SUM;
    opcode = frame[15:8];
    kind   = frame[23:16];
    value  = frame[55:24];
    if (opcode != set_code) return clqc_pkg::RX_OK;
    // voltage wins over current, current over rate when codes collide
    if (kind == voltage_code) begin
      voltage_setting = value;
    end else if (kind == current_code) begin
      current_setting = value;
    end else if (kind == rate_code) begin
      if (value == 0) return clqc_pkg::RX_ZERO_RATE;
      delay_setting = 20'(32'd1000000 / value);
    end
    return clqc_pkg::RX_OK;
  endfunction

  // Advance the model by one accepted beat and return the expected result.
  function automatic link_result_t step_link_model(input link_item_t it);
    link_result_t r;
    logic [55:0]  entry;
    r.tx_valid  = 1'b0;
    r.tx_frame  = '0;
    r.rx_status = clqc_pkg::RX_NONE;
    r.dropped   = 1'b0;
    case (it.op)
      clqc_pkg::OP_ENQ: begin
        if (held_entries >= QUEUE_DEPTH) begin
          r.dropped = 1'b1;
          enq_dropped++;
        end else begin
          cmd_store[wr_ptr] = {it.dev_value, it.dev_kind, it.dev_opcode, it.dev_status};
          wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH;
          held_entries++;
        end
      end
      clqc_pkg::OP_TX: begin
        if (held_entries > 0) begin
          entry = cmd_store[rd_ptr];
          rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
          held_entries--;
          r.tx_valid = 1'b1;
          r.tx_frame = {body_sum(entry), entry};
          frames_sent++;
        end
      end
      clqc_pkg::OP_RX: begin
        r.rx_status = apply_host_frame(it.rx_frame, it.rx_length);
        if (r.rx_status == clqc_pkg::RX_OK) host_ok++;
        else host_rejected++;
      end
      default: ;
    endcase
    r.voltage = voltage_setting;
    r.current = current_setting;
    r.delay   = delay_setting;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset and timeout
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ends a hung run; the slowest correct run needs well under a tenth of this
  initial begin
    #1000000;
    $display("command_link_queue_and_checksum_frames regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: present the next pending beat at the falling edge, hold it until
  // the rising edge that accepts it. Prediction happens at that edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      expected_beats.push_back(step_link_model(cur_beat));
      in_taken = 1'b1;
      beats_in++;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      in_taken = 1'b0;
      if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_beat = pending_beats.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= cur_beat.op;
        in_tdata  <= {1'b0, cur_beat.rx_length, cur_beat.rx_frame, cur_beat.dev_value,
                      cur_beat.dev_kind, cur_beat.dev_opcode, cur_beat.dev_status};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure: drop tready at random per the current phase.
  always @(negedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each accepted result beat with the oldest prediction
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    link_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      beats_out++;
      if (expected_beats.size() == 0) begin
        $error("result beat with no prediction pending: tdata 0x%0h", out_tdata);
        error_count++;
      end else begin
        want = expected_beats.pop_front();
        check_field("tx_valid", 64'(want.tx_valid), 64'(out_tuser));
        check_field("tx_frame", want.tx_frame, out_tdata[63:0]);
        check_field("rx_status", 64'(want.rx_status), 64'(out_tdata[66:64]));
        check_field("queue_dropped", 64'(want.dropped), 64'(out_tdata[67]));
        check_field("target_voltage", 64'(want.voltage), 64'(out_tdata[99:68]));
        check_field("target_current", 64'(want.current), 64'(out_tdata[131:100]));
        check_field("sample_delay", 64'(want.delay), 64'(out_tdata[151:132]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic link_item_t blank_item(input clqc_pkg::op_t op);
    link_item_t it;
    it.op         = op;
    it.dev_status = '0;
    it.dev_opcode = '0;
    it.dev_kind   = '0;
    it.dev_value  = '0;
    it.rx_frame   = '0;
    it.rx_length  = '0;
    return it;
  endfunction

  function automatic link_item_t enq_item(input logic [7:0] status, input logic [7:0] opcode,
                                          input logic [7:0] kind, input logic [31:0] value);
    link_item_t it;
    it = blank_item(clqc_pkg::OP_ENQ);
    it.dev_status = status;
    it.dev_opcode = opcode;
    it.dev_kind   = kind;
    it.dev_value  = value;
    return it;
  endfunction

  function automatic link_item_t rx_item(input logic [63:0] frame, input logic [6:0] len);
    link_item_t it;
    it = blank_item(clqc_pkg::OP_RX);
    it.rx_frame  = frame;
    it.rx_length = len;
    return it;
  endfunction

  function automatic link_item_t random_enq();
    return enq_item(8'($urandom), 8'($urandom), 8'($urandom), $urandom);
  endfunction

  // Mostly well-formed host frames aimed at the live codes; the rest is a
  // corrupted checksum or random bytes with a random length.
  function automatic link_item_t random_host_frame();
    int unsigned pick;
    logic [7:0]  opcode, kind;
    logic [31:0] value;
    pick   = $urandom_range(0, 99);
    opcode = ($urandom_range(0, 9) < 8) ? set_code : 8'($urandom);
    case ($urandom_range(0, 3))
      0:       kind = voltage_code;
      1:       kind = current_code;
      2:       kind = rate_code;
      default: kind = 8'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       value = '0;
      1, 2, 3: value = $urandom_range(1, 2000);
      default: value = $urandom;
    endcase
    if (pick < 70)
      return rx_item(host_frame(8'($urandom), opcode, kind, value), clqc_pkg::FRAME_BYTES);
    if (pick < 85)
      return rx_item(host_frame(8'($urandom), opcode, kind, value) ^
                     (64'd1 << (56 + $urandom_range(0, 7))), clqc_pkg::FRAME_BYTES);
    return rx_item({$urandom, $urandom}, 7'($urandom_range(0, 64)));
  endfunction

  // Queue about n random beats: start with an overfill and a full drain, then
  // mix bursts of enqueues and transmit slots with single host frames and unused-kind beats.
  task automatic add_random_beats(input int unsigned n);
    int unsigned added, burst, pick;
    added = 0;
    for (int i = 0; i <= QUEUE_DEPTH; i++) pending_beats.push_back(random_enq());
    for (int i = 0; i <= QUEUE_DEPTH; i++) pending_beats.push_back(blank_item(clqc_pkg::OP_TX));
    added = 2 * (QUEUE_DEPTH + 1);
    while (added < n) begin
      pick  = $urandom_range(0, 99);
      burst = $urandom_range(1, 20);
      if (pick < 35) begin
        for (int i = 0; i < burst; i++) pending_beats.push_back(random_enq());
        added += burst;
      end else if (pick < 60) begin
        for (int i = 0; i < burst; i++) pending_beats.push_back(blank_item(clqc_pkg::OP_TX));
        added += burst;
      end else if (pick < 96) begin
        pending_beats.push_back(random_host_frame());
        added++;
      end else begin
        pending_beats.push_back(blank_item(clqc_pkg::OP_NONE));
        added++;
      end
    end
  endtask

  // Register write; mirror it into the model once the handshake completes.
  task automatic write_setting(input clqc_pkg::cfg_idx_t idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      clqc_pkg::CFG_SET_OPCODE: set_code     = val;
      clqc_pkg::CFG_VOLT_TYPE:  voltage_code = val;
      clqc_pkg::CFG_CURR_TYPE:  current_code = val;
      clqc_pkg::CFG_RATE_TYPE:  rate_code    = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all_settings(input logic [7:0] s, input logic [7:0] v,
                                    input logic [7:0] c, input logic [7:0] r);
    write_setting(clqc_pkg::CFG_SET_OPCODE, s);
    write_setting(clqc_pkg::CFG_VOLT_TYPE, v);
    write_setting(clqc_pkg::CFG_CURR_TYPE, c);
    write_setting(clqc_pkg::CFG_RATE_TYPE, r);
  endtask

  // Hold until every pending beat is in and every prediction has its result.
  task automatic wait_drained();
    while (pending_beats.size() > 0 || in_tvalid || expected_beats.size() > 0)
      @(posedge clk);
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] code_a;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = clqc_pkg::OP_NONE;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = clqc_pkg::CFG_SET_OPCODE;
    cfg_data   = '0;
    in_taken   = 1'b0;
    wr_ptr = 0; rd_ptr = 0; held_entries = 0;
    voltage_setting = '0; current_setting = '0; delay_setting = '0;
    set_code = 8'd0; voltage_code = 8'd0; current_code = 8'd1; rate_code = 8'd2;
    error_count = 0; beats_in = 0; beats_out = 0;
    frames_sent = 0; enq_dropped = 0; host_ok = 0; host_rejected = 0;
    send_idle_pct = 26;
    recv_idle_pct = 75;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Phase 1: low-end codes, sender sparse idling, receiver heavy stalls.
    write_all_settings(8'h00, 8'h00, 8'h01, 8'h02);

    // directed corner cases
    pending_beats.push_back(blank_item(clqc_pkg::OP_NONE));         // undefined op
    pending_beats.push_back(blank_item(clqc_pkg::OP_TX));           // slot on empty queue
    pending_beats.push_back(rx_item('1, 7'd0));                     // shortest length
    pending_beats.push_back(rx_item('0, 7'd64));                    // length 64
    pending_beats.push_back(rx_item(host_frame(8'h11, 8'h00, 8'h00, 32'h1234_5678) ^
                                    (64'd1 << 63), clqc_pkg::FRAME_BYTES)); // bad checksum
    pending_beats.push_back(rx_item('0, clqc_pkg::FRAME_BYTES));    // all-zero valid frame
    pending_beats.push_back(rx_item(host_frame(8'hFF, 8'h00, 8'h00, 32'hFFFF_FFFF),
                                    clqc_pkg::FRAME_BYTES));        // voltage to -1
    pending_beats.push_back(rx_item(host_frame(8'h00, 8'h00, 8'h01, 32'h8000_0000),
                                    clqc_pkg::FRAME_BYTES));        // current to min
    pending_beats.push_back(rx_item(host_frame(8'h00, 8'h00, 8'h02, 32'd0),
                                    clqc_pkg::FRAME_BYTES));        // zero rate
    pending_beats.push_back(rx_item(host_frame(8'h00, 8'h00, 8'h02, 32'd1),
                                    clqc_pkg::FRAME_BYTES));        // largest delay
    pending_beats.push_back(rx_item(host_frame(8'h00, 8'h00, 8'h02, 32'hFFFF_FFFF),
                                    clqc_pkg::FRAME_BYTES));        // delay rounds to zero
    pending_beats.push_back(rx_item(host_frame(8'h00, 8'h00, 8'h02, 32'd3),
                                    clqc_pkg::FRAME_BYTES));
    pending_beats.push_back(rx_item(host_frame(8'h00, 8'h55, 8'h02, 32'd7),
                                    clqc_pkg::FRAME_BYTES));        // other opcode
    pending_beats.push_back(rx_item(host_frame(8'h00, 8'h00, 8'h77, 32'd9),
                                    clqc_pkg::FRAME_BYTES));        // unknown type
    pending_beats.push_back(enq_item(8'h00, 8'h00, 8'h00, 32'h0000_0000));
    pending_beats.push_back(enq_item(8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
    pending_beats.push_back(enq_item(8'h01, 8'h02, 8'h03, 32'h0405_0607));
    repeat (4) pending_beats.push_back(blank_item(clqc_pkg::OP_TX)); // last one finds it empty
    pending_beats.push_back(rx_item(host_frame(8'h00, 8'h00, 8'h00, 32'd5), 7'd7));
    pending_beats.push_back(rx_item(host_frame(8'h00, 8'h00, 8'h00, 32'd5), 7'd9));

    add_random_beats(PHASE_ITEMS);
    wait_drained();

    // Phase 2: all codes at the top and equal, so voltage wins every set that hits a code;
    // sender idles heavily, receiver lightly.
    write_all_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_idle_pct = 75;
    recv_idle_pct = 26;
    add_random_beats(PHASE_ITEMS);
    wait_drained();

    // Phase 3: random codes with current and rate colliding; no idling.
    code_a = 8'($urandom);
    write_all_settings(8'($urandom), code_a, code_a ^ 8'h5A, code_a ^ 8'h5A);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_beats(PHASE_ITEMS);
    wait_drained();

    // let any stray result beat show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input beats and %0d result beats in three code/idle phases",
             beats_in, beats_out);
    $display("frames sent %0d, enqueues dropped %0d, host frames ok %0d, rejected %0d",
             frames_sent, enq_dropped, host_ok, host_rejected);
    if (error_count == 0 && expected_beats.size() == 0) begin
      $display("command_link_queue_and_checksum_frames regression: pass");
    end else begin
      $display("command_link_queue_and_checksum_frames regression: fail");
    end
    $finish;
  end

endmodule

// ===== command_link_queue_and_checksum_frames.f =====
rtl/clqc_pkg.sv
rtl/clqc_div.sv
rtl/command_link_queue_and_checksum_frames.sv
dv/command_link_queue_and_checksum_frames_tb.sv
